// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the conditioner RTL.
// Depends on nothing; the asserting module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GPEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GPEC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GPEC_ASSERT(lbl, prop, msg)
`define GPEC_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/gpec_pkg.sv -----
// Shared types and constants for the gamepad poll event conditioner.
// Used by every module of the block; depends on nothing.
package gpec_pkg;

  localparam int NUM_BUTTONS_DEF     = 14;
  localparam int NUM_AXES_DEF        = 6;
  localparam int FIRST_REPEAT_DEF    = 10;

  localparam int BTN_IN_W    = 14;
  localparam int AXIS_IN_NUM = 6;
  localparam int AXIS_W      = 16;
  localparam int TIME_W      = 32;
  localparam int KEY_W       = 5;
  localparam int DLY_W       = 16;
  localparam int THR_W       = 15;
  localparam int CNT_W       = 32;
  localparam int NORTH_BUTTON = 3;

  localparam int IN_BTN_LSB   = 0;
  localparam int IN_TOUCH_BIT = 14;
  localparam int IN_FOCUS_BIT = 15;
  localparam int IN_CONN_BIT  = 16;
  localparam int IN_NOW_LSB   = 17;
  localparam int IN_AXIS_LSB  = 49;
  localparam int IN_USED_W    = IN_AXIS_LSB + AXIS_IN_NUM * AXIS_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_KEY_LSB  = 0;
  localparam int OUT_VAL_LSB  = 5;
  localparam int OUT_CNT_LSB  = 21;
  localparam int OUT_USED_W   = OUT_CNT_LSB + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DLY_W-1:0] RESET_REPEAT_DELAY  = 16'd400;
  localparam logic [DLY_W-1:0] RESET_REPEAT_PERIOD = 16'd120;
  localparam logic [THR_W-1:0] RESET_DEAD_ZONE     = 15'd327;
  localparam logic [THR_W-1:0] RESET_CHANGE_TOL    = 15'd3;
  localparam logic [THR_W-1:0] RESET_ACTIVITY_THR  = 15'd5898;

  typedef enum logic [1:0] {
    KIND_PRESS,
    KIND_RELEASE,
    KIND_REPEAT,
    KIND_ANALOG
  } evt_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_DELAY,
    REG_REPEAT_PERIOD,
    REG_DEAD_ZONE,
    REG_CHANGE_TOL,
    REG_ACTIVITY_THR
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COND,
    ST_DECIDE,
    ST_DRAIN
  } ctl_state_t;

  typedef struct packed {
    logic cond;
    logic commit;
    logic active;
  } lane_ctl_t;

  typedef struct packed {
    logic              valid;
    evt_kind_t         kind;
    logic              count;
    logic [AXIS_W-1:0] value;
  } lane_evt_t;

endpackage

// ----- rtl/gpec_button_lane.sv -----
// One button lane: held level, edge detection and optional auto-repeat timer.
// Depends on gpec_pkg.
module gpec_button_lane #(
  parameter bit IS_REPEAT = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gpec_pkg::lane_ctl_t           ctl,
  input  logic                          pressed,
  input  logic [gpec_pkg::TIME_W-1:0]   now,
  input  logic [gpec_pkg::DLY_W-1:0]    repeat_delay,
  input  logic [gpec_pkg::DLY_W-1:0]    repeat_period,
  output gpec_pkg::lane_evt_t           evt
);

  logic                        held_r, held_nxt;
  logic [gpec_pkg::TIME_W-1:0] deadline_r, deadline_nxt;
  logic [gpec_pkg::TIME_W-1:0] since;
  logic                        due;

  assign since = now - deadline_r;
  assign due   = IS_REPEAT && !since[gpec_pkg::TIME_W-1];

  always_comb begin
    evt          = '0;
    held_nxt     = held_r;
    deadline_nxt = deadline_r;
    if (!ctl.active) begin
      if (held_r) begin
        evt.valid = 1'b1;
        evt.kind  = gpec_pkg::KIND_RELEASE;
        held_nxt  = 1'b0;
      end
    end else if (pressed != held_r) begin
      evt.valid = 1'b1;
      evt.count = 1'b1;
      evt.kind  = pressed ? gpec_pkg::KIND_PRESS : gpec_pkg::KIND_RELEASE;
      held_nxt  = pressed;
      if (pressed && IS_REPEAT) begin
        deadline_nxt = now + gpec_pkg::TIME_W'(repeat_delay);
      end
    end else if (pressed && due) begin
      evt.valid    = 1'b1;
      evt.kind     = gpec_pkg::KIND_REPEAT;
      deadline_nxt = now + gpec_pkg::TIME_W'(repeat_period);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= 1'b0;
      deadline_r <= '0;
    end else if (ctl.commit) begin
      held_r     <= held_nxt;
      deadline_r <= deadline_nxt;
    end
  end

endmodule

// ----- rtl/gpec_axis_lane.sv -----
// One axis lane: inversion, deadzone, change test and last-value memory.
// Depends on gpec_pkg.
module gpec_axis_lane #(
  parameter bit IS_INVERTED = 1'b0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gpec_pkg::lane_ctl_t          ctl,
  input  logic [gpec_pkg::AXIS_W-1:0]  raw,
  input  logic [gpec_pkg::THR_W-1:0]   dead_zone,
  input  logic [gpec_pkg::THR_W-1:0]   change_tolerance,
  input  logic [gpec_pkg::THR_W-1:0]   activity_threshold,
  output gpec_pkg::lane_evt_t          evt
);

  localparam int W  = gpec_pkg::AXIS_W;
  localparam int MW = W + 1;
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]  inv_v, cond_v, v_r, last_r, last_nxt;
  logic [MW-1:0] cond_ext, cond_mag, vmag_r, diff, dmag;
  logic          moved;

  always_comb begin
    if (IS_INVERTED) begin
      inv_v = (raw == MIN_VAL) ? MAX_VAL : (W'(0) - raw);
    end else begin
      inv_v = raw;
    end
    cond_ext = {inv_v[W-1], inv_v};
    cond_mag = inv_v[W-1] ? (MW'(0) - cond_ext) : cond_ext;
    cond_v   = (cond_mag <= MW'(dead_zone)) ? '0 : inv_v;
  end

  always_ff @(posedge clk) begin
    if (ctl.cond) begin
      v_r    <= cond_v;
      vmag_r <= (cond_mag <= MW'(dead_zone)) ? '0 : cond_mag;
    end
  end

  assign diff  = {v_r[W-1], v_r} - {last_r[W-1], last_r};
  assign dmag  = diff[MW-1] ? (MW'(0) - diff) : diff;
  assign moved = (dmag > MW'(change_tolerance)) || (v_r != '0);

  always_comb begin
    evt      = '0;
    evt.kind = gpec_pkg::KIND_ANALOG;
    last_nxt = last_r;
    if (!ctl.active) begin
      evt.valid = (last_r != '0);
      last_nxt  = '0;
    end else if (moved) begin
      evt.valid = 1'b1;
      evt.count = (vmag_r > MW'(activity_threshold));
      evt.value = v_r;
      last_nxt  = v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ctl.commit) begin
      last_r <= last_nxt;
    end
  end

endmodule

// ----- rtl/gpec_merge.sv -----
// Merging stage: walks the lane results in binding order and issues events.
// Holds the output register and the activity counter. Depends on gpec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gpec_merge #(
  parameter int NUM_SLOTS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  gpec_pkg::lane_evt_t          slot_in [NUM_SLOTS],
  input  logic                         out_tready,
  output logic                         busy,
  output logic                         out_valid,
  output gpec_pkg::evt_kind_t          out_kind,
  output logic [gpec_pkg::KEY_W-1:0]   out_key,
  output logic [gpec_pkg::AXIS_W-1:0]  out_value,
  output logic [gpec_pkg::CNT_W-1:0]   out_count,
  output logic                         out_last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  gpec_pkg::lane_evt_t         slot_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]        pend;
  logic                        later_pend;
  logic                        out_free;
  logic                        advance;
  logic                        emit;
  logic [IDX_W-1:0]            idx_r;
  logic [gpec_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r;
  gpec_pkg::evt_kind_t         out_kind_r;
  logic [gpec_pkg::KEY_W-1:0]  out_key_r;
  logic [gpec_pkg::AXIS_W-1:0] out_value_r;
  logic [gpec_pkg::CNT_W-1:0]  out_count_r;
  logic                        out_last_r;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    gpec_pkg::lane_evt_t next_slot;
    assign pend[k] = slot_r[k].valid;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_body
      assign next_slot = slot_r[k+1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        slot_r[k] <= '0;
      end else if (load) begin
        slot_r[k] <= slot_in[k];
      end else if (advance) begin
        slot_r[k] <= next_slot;
      end
    end
  end

  assign busy       = |pend;
  assign later_pend = |(pend >> 1);
  assign out_free   = !out_valid_r || out_tready;
  assign advance    = busy && (!slot_r[0].valid || out_free);
  assign emit       = advance && slot_r[0].valid;
  assign cnt_nxt    = cnt_r + gpec_pkg::CNT_W'(slot_r[0].count);

  always_ff @(posedge clk) begin
    if (load) begin
      idx_r <= '0;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= slot_r[0].kind;
      out_key_r   <= gpec_pkg::KEY_W'(idx_r);
      out_value_r <= slot_r[0].value;
      out_count_r <= cnt_nxt;
      out_last_r  <= !later_pend;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_key   = out_key_r;
  assign out_value = out_value_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

  `GPEC_NEVER(a_load_while_busy, load && busy, "new poll loaded while events still pending")
  `GPEC_ASSERT(a_last_ends_run, emit && !later_pend |=> !busy, "pending events after last")
  `GPEC_ASSERT(a_cnt_only_on_emit, !(emit && slot_r[0].count) |=> $stable(cnt_r), "stray count")
  `GPEC_ASSERT(a_emit_shows, emit |=> out_valid_r, "issued event not presented")

endmodule

// ----- rtl/gamepad_poll_event_conditioner_unit.sv -----
// Gamepad poll event conditioner, top level. Instantiates the button lanes,
// the axis lanes and the merging stage; depends on gpec_pkg.
//
// Each accepted poll is conditioned by one lane per button and one per axis
// working side by side, and the merging stage then issues the resulting
// events in binding order, buttons first, one event per clock cycle at most.
// After the accepting cycle a poll passes through the conditioning and
// decide states, the merging stage walks the slots up to its last event,
// and the control then returns to idle. The input is therefore held off
// from each accepted poll until that return to idle, for longer the more
// slots the walk covers and while the result side stalls. The next poll
// is taken only after the last event of the previous one has entered the
// output register and the control has returned to idle.
// A poll that causes no event produces nothing on the result channel.
// Configuration writes are always accepted and should be made while idle.
module gamepad_poll_event_conditioner_unit #(
  parameter int NUM_BUTTONS         = gpec_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES            = gpec_pkg::NUM_AXES_DEF,
  parameter int FIRST_REPEAT_BUTTON = gpec_pkg::FIRST_REPEAT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // button_bits[13:0], touchpad, focused, connected, now_ms[31:0],
  // axis_left_x, axis_left_y, axis_right_x, axis_right_y,
  // trigger_left, trigger_right (16 bits each), zero fill.
  input  logic [gpec_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key_index[4:0], analog_value[15:0], event_count[31:0], zero fill.
  output logic [gpec_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // event_kind[1:0], zero fill.
  output logic [gpec_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpec_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NUM_SLOTS = NUM_BUTTONS + NUM_AXES;

  logic [gpec_pkg::DLY_W-1:0]     repeat_delay_r, repeat_period_r;
  logic [gpec_pkg::THR_W-1:0]     dead_zone_r, change_tol_r, activity_thr_r;
  logic [gpec_pkg::IN_USED_W-1:0] in_data_r;
  gpec_pkg::ctl_state_t           state_r, state_nxt;
  gpec_pkg::lane_ctl_t            lane_ctl;
  gpec_pkg::lane_evt_t            slot_evt [NUM_SLOTS];
  logic [gpec_pkg::TIME_W-1:0]    now;
  logic                           merge_busy;
  logic                           m_valid;
  gpec_pkg::evt_kind_t            m_kind;
  logic [gpec_pkg::KEY_W-1:0]     m_key;
  logic [gpec_pkg::AXIS_W-1:0]    m_value;
  logic [gpec_pkg::CNT_W-1:0]     m_count;
  logic                           m_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_r  <= gpec_pkg::RESET_REPEAT_DELAY;
      repeat_period_r <= gpec_pkg::RESET_REPEAT_PERIOD;
      dead_zone_r     <= gpec_pkg::RESET_DEAD_ZONE;
      change_tol_r    <= gpec_pkg::RESET_CHANGE_TOL;
      activity_thr_r  <= gpec_pkg::RESET_ACTIVITY_THR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gpec_pkg::reg_idx_t'(cfg_index))
        gpec_pkg::REG_REPEAT_DELAY:  repeat_delay_r  <= cfg_data;
        gpec_pkg::REG_REPEAT_PERIOD: repeat_period_r <= cfg_data;
        gpec_pkg::REG_DEAD_ZONE:     dead_zone_r     <= cfg_data[gpec_pkg::THR_W-1:0];
        gpec_pkg::REG_CHANGE_TOL:    change_tol_r    <= cfg_data[gpec_pkg::THR_W-1:0];
        gpec_pkg::REG_ACTIVITY_THR:  activity_thr_r  <= cfg_data[gpec_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[gpec_pkg::IN_USED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    lane_ctl.cond   = 1'b0;
    lane_ctl.commit = 1'b0;
    lane_ctl.active = in_data_r[gpec_pkg::IN_FOCUS_BIT] && in_data_r[gpec_pkg::IN_CONN_BIT];
    unique case (state_r)
      gpec_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = gpec_pkg::ST_COND;
        end
      end
      gpec_pkg::ST_COND: begin
        lane_ctl.cond = 1'b1;
        state_nxt     = gpec_pkg::ST_DECIDE;
      end
      gpec_pkg::ST_DECIDE: begin
        lane_ctl.commit = 1'b1;
        state_nxt       = gpec_pkg::ST_DRAIN;
      end
      gpec_pkg::ST_DRAIN: begin
        if (!merge_busy) begin
          state_nxt = gpec_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpec_pkg::ST_IDLE;
    endcase
  end

  assign now = in_data_r[gpec_pkg::IN_NOW_LSB +: gpec_pkg::TIME_W];

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic pressed;
    if (i == gpec_pkg::NORTH_BUTTON) begin : g_north
      assign pressed = in_data_r[gpec_pkg::IN_BTN_LSB + i] |
                       in_data_r[gpec_pkg::IN_TOUCH_BIT];
    end else if (i < gpec_pkg::BTN_IN_W) begin : g_plain
      assign pressed = in_data_r[gpec_pkg::IN_BTN_LSB + i];
    end else begin : g_absent
      assign pressed = 1'b0;
    end
    gpec_button_lane #(
      .IS_REPEAT(i >= FIRST_REPEAT_BUTTON)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (lane_ctl),
      .pressed      (pressed),
      .now          (now),
      .repeat_delay (repeat_delay_r),
      .repeat_period(repeat_period_r),
      .evt          (slot_evt[i])
    );
  end

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
    logic [gpec_pkg::AXIS_W-1:0] raw;
    if (j < gpec_pkg::AXIS_IN_NUM) begin : g_present
      assign raw = in_data_r[gpec_pkg::IN_AXIS_LSB + j * gpec_pkg::AXIS_W +: gpec_pkg::AXIS_W];
    end else begin : g_absent
      assign raw = '0;
    end
    gpec_axis_lane #(
      .IS_INVERTED((j == 1) || (j == 3))
    ) u_lane (
      .clk               (clk),
      .rst_n             (rst_n),
      .ctl               (lane_ctl),
      .raw               (raw),
      .dead_zone         (dead_zone_r),
      .change_tolerance  (change_tol_r),
      .activity_threshold(activity_thr_r),
      .evt               (slot_evt[NUM_BUTTONS + j])
    );
  end

  gpec_merge #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (lane_ctl.commit),
    .slot_in   (slot_evt),
    .out_tready(out_tready),
    .busy      (merge_busy),
    .out_valid (m_valid),
    .out_kind  (m_kind),
    .out_key   (m_key),
    .out_value (m_value),
    .out_count (m_count),
    .out_last  (m_last)
  );

  assign out_tvalid = m_valid;
  assign out_tlast  = m_last;
  assign out_tuser  = gpec_pkg::OUT_TUSER_W'(m_kind);
  assign out_tdata  = {{(gpec_pkg::OUT_TDATA_W - gpec_pkg::OUT_USED_W){1'b0}},
                       m_count, m_value, m_key};

endmodule
